// File: rtl/cnpr_pkg.sv
package cnpr_pkg;

    localparam int FRAME_FIELD_W = 6;
    localparam int COUNT_W       = 32;

    typedef enum logic [1:0] {
        OP_HIT   = 2'd0,
        OP_FAULT = 2'd1,
        OP_CLOCK = 2'd2,
        OP_NRU   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIT,
        ST_SWEEP,
        ST_NRU,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic hit_wr;
        logic sweep_step;
        logic nru_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic rd_ref;
        logic rd_mod;
        logic cur_last;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/cnpr_ram.sv
module cnpr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/cnpr_ctrl.sv
module cnpr_ctrl import cnpr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  status_t     status,
    output cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.cur_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_HIT:  state_next = ST_HIT;
                        OP_NRU:  state_next = ST_NRU;
                        default: state_next = ST_SWEEP;
                    endcase
                end
            end
            ST_HIT:
            begin
                cmd.hit_wr = 1'b1;
                state_next = ST_FINISH;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (!status.rd_ref)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_NRU:
            begin
                cmd.nru_step = 1'b1;
                if ((!status.rd_ref && !status.rd_mod) || status.cur_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/cnpr_dpath.sv
module cnpr_dpath import cnpr_pkg::*; #(
    parameter int FRAME_COUNT = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [1:0]               opcode,
    input  logic [FRAME_FIELD_W-1:0] frame,
    input  logic                     is_write,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FRAME_FIELD_W-1:0] victim_frame,
    output logic                     victim_found,
    output logic [COUNT_W-1:0]       reference_count,
    output logic [COUNT_W-1:0]       replacement_count,
    output logic [COUNT_W-1:0]       fault_count
);

    localparam int            FW   = $clog2(FRAME_COUNT);
    localparam logic [FW-1:0] LAST = FW'(FRAME_COUNT - 1);

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    logic [1:0]               op_reg;
    logic [FW-1:0]            hit_addr_reg;
    logic                     hit_ok_reg;
    logic                     wr_reg;
    logic [FW-1:0]            cur_reg;
    logic [FW-1:0]            cur_next;
    logic [FW-1:0]            victim_reg;
    logic [FW-1:0]            victim_next;
    logic                     found_reg;
    logic                     found_next;
    logic [FW-1:0]            alt_reg;
    logic [FW-1:0]            alt_next;
    logic                     alt_found_reg;
    logic                     alt_found_next;
    logic [FW-1:0]            hand_reg;
    logic [FW-1:0]            hand_next;
    logic [COUNT_W-1:0]       ref_cnt_reg;
    logic [COUNT_W-1:0]       ref_cnt_next;
    logic [COUNT_W-1:0]       rep_cnt_reg;
    logic [COUNT_W-1:0]       rep_cnt_next;
    logic [COUNT_W-1:0]       flt_cnt_reg;
    logic [COUNT_W-1:0]       flt_cnt_next;
    logic                     out_valid_reg;
    logic [FRAME_FIELD_W-1:0] out_victim_reg;
    logic                     out_found_reg;
    logic [COUNT_W-1:0]       out_ref_reg;
    logic [COUNT_W-1:0]       out_rep_reg;
    logic [COUNT_W-1:0]       out_flt_reg;

    logic                     frame_ok;
    logic [FW+5:0]            frame_ext;
    logic [FW-1:0]            frame_addr;
    logic [FW-1:0]            cur_inc;
    logic [FW-1:0]            victim_inc;
    logic [FW+5:0]            victim_ext;
    logic                     op_clock;
    logic                     op_ref;
    logic                     rd_ref;
    logic                     rd_mod;
    logic [1:0]               rdata;
    logic [FW-1:0]            raddr;
    logic                     we;
    logic [FW-1:0]            waddr;
    logic [1:0]               wdata;

    assign frame_ok   = (32'(frame) < FRAME_COUNT);
    assign frame_ext  = {{FW{1'b0}}, frame};
    assign frame_addr = frame_ok ? frame_ext[FW-1:0] : '0;
    assign cur_inc    = (cur_reg == LAST) ? '0 : cur_reg + FW'(1);
    assign victim_inc = (victim_reg == LAST) ? '0 : victim_reg + FW'(1);
    assign victim_ext = {6'b0, victim_reg};
    assign op_clock   = op_reg inside {OP_FAULT, OP_CLOCK};
    assign op_ref     = op_reg inside {OP_HIT, OP_FAULT};
    assign rd_ref     = rdata[1];
    assign rd_mod     = rdata[0];

    assign status.rd_ref   = rd_ref;
    assign status.rd_mod   = rd_mod;
    assign status.cur_last = (cur_reg == LAST);
    assign status.out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        if (cmd.capture)
        begin
            case (opcode)
                OP_HIT:   raddr = frame_addr;
                OP_FAULT: raddr = hand_reg;
                OP_CLOCK: raddr = hand_reg;
                default:  raddr = '0;
            endcase
        end
        else
        begin
            raddr = cur_inc;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = 2'b00;
        if (cmd.clear_wr)
        begin
            we = 1'b1;
        end
        else if (cmd.hit_wr)
        begin
            we    = hit_ok_reg;
            waddr = hit_addr_reg;
            wdata = {1'b1, rd_mod | wr_reg};
        end
        else if (cmd.sweep_step)
        begin
            we    = rd_ref;
            wdata = {1'b0, rd_mod};
        end
        else if (cmd.finish)
        begin
            we    = found_reg;
            waddr = victim_reg;
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        victim_next    = victim_reg;
        found_next     = found_reg;
        alt_next       = alt_reg;
        alt_found_next = alt_found_reg;
        hand_next      = hand_reg;
        ref_cnt_next   = ref_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        flt_cnt_next   = flt_cnt_reg;
        if (cmd.capture)
        begin
            cur_next       = raddr;
            victim_next    = '0;
            found_next     = 1'b0;
            alt_found_next = 1'b0;
        end
        if (cmd.clear_wr)
        begin
            cur_next = cur_inc;
        end
        if (cmd.sweep_step)
        begin
            cur_next = cur_inc;
            if (!rd_ref)
            begin
                victim_next = cur_reg;
                found_next  = 1'b1;
            end
        end
        if (cmd.nru_step)
        begin
            cur_next = cur_inc;
            if (!rd_ref && !rd_mod)
            begin
                victim_next = cur_reg;
                found_next  = 1'b1;
            end
            else
            begin
                if (!rd_ref && !alt_found_reg)
                begin
                    alt_next       = cur_reg;
                    alt_found_next = 1'b1;
                end
                if (cur_reg == LAST)
                begin
                    victim_next = (!rd_ref && !alt_found_reg) ? cur_reg : alt_reg;
                    found_next  = !rd_ref || alt_found_reg;
                end
            end
        end
        if (cmd.finish)
        begin
            if (op_clock)
            begin
                hand_next = victim_inc;
            end
            if (op_ref)
            begin
                ref_cnt_next = sat_inc(ref_cnt_reg);
            end
            if (op_reg == OP_FAULT)
            begin
                flt_cnt_next = sat_inc(flt_cnt_reg);
            end
            if (found_reg)
            begin
                rep_cnt_next = sat_inc(rep_cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            hand_reg      <= '0;
            ref_cnt_reg   <= '0;
            rep_cnt_reg   <= '0;
            flt_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            hand_reg    <= hand_next;
            ref_cnt_reg <= ref_cnt_next;
            rep_cnt_reg <= rep_cnt_next;
            flt_cnt_reg <= flt_cnt_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg    <= victim_next;
        found_reg     <= found_next;
        alt_reg       <= alt_next;
        alt_found_reg <= alt_found_next;
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            hit_addr_reg <= frame_addr;
            hit_ok_reg   <= frame_ok;
            wr_reg       <= is_write;
        end
        if (cmd.finish)
        begin
            out_victim_reg <= found_reg ? victim_ext[FRAME_FIELD_W-1:0] : '0;
            out_found_reg  <= found_reg;
            out_ref_reg    <= ref_cnt_next;
            out_rep_reg    <= rep_cnt_next;
            out_flt_reg    <= flt_cnt_next;
        end
    end

    cnpr_ram #(
        .WIDTH (2),
        .DEPTH (FRAME_COUNT)
    ) u_bits_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_valid         = out_valid_reg;
    assign victim_frame      = out_victim_reg;
    assign victim_found      = out_found_reg;
    assign reference_count   = out_ref_reg;
    assign replacement_count = out_rep_reg;
    assign fault_count       = out_flt_reg;

    a_finish_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result loaded while output item is stalled");

    a_faults_le_refs: assert property (@(posedge clk) disable iff (!rst_n)
        flt_cnt_reg <= ref_cnt_reg)
        else $error("fault count exceeds reference count");

    a_ref_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ref_cnt_reg >= $past(ref_cnt_reg))
        else $error("reference count decreased");

    a_sweep_stop_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_step && !rd_ref) |=> found_reg)
        else $error("clock sweep stopped without a victim");

endmodule

// File: rtl/clock_nru_page_replacement.sv
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------------
// input    in_valid / in_stall  opcode, frame, is_write
// output   out_valid/out_stall  victim_frame, victim_found, reference_count,
//                               replacement_count, fault_count
//
// One item at a time. A hit passes through the HIT and FINISH states before its
// result is registered. A clock sweep visits one frame per cycle through the bit
// RAM read port. An NRU scan reads one frame per cycle from frame 0. After reset a
// clearing pass over all FRAME_COUNT frames zeroes the bit RAM while in_stall
// stays high. A stalled result is held in the output register; the next item is
// accepted meanwhile and waits at its end for the slot.
module clock_nru_page_replacement import cnpr_pkg::*; #(
    parameter int FRAME_COUNT = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               opcode,
    input  logic [FRAME_FIELD_W-1:0] frame,
    input  logic                     is_write,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [FRAME_FIELD_W-1:0] victim_frame,
    output logic                     victim_found,
    output logic [COUNT_W-1:0]       reference_count,
    output logic [COUNT_W-1:0]       replacement_count,
    output logic [COUNT_W-1:0]       fault_count
);

    cmd_t    cmd;
    status_t status;

    cnpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    cnpr_dpath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .opcode            (opcode),
        .frame             (frame),
        .is_write          (is_write),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .victim_frame      (victim_frame),
        .victim_found      (victim_found),
        .reference_count   (reference_count),
        .replacement_count (replacement_count),
        .fault_count       (fault_count)
    );

endmodule

// File: dv/tb.sv
module tb;
    import cnpr_pkg::*;

    localparam int FRAME_COUNT = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CALM_ITEMS = 150;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [FRAME_FIELD_W-1:0] victim_frame;
        logic                     victim_found;
        logic [COUNT_W-1:0]       reference_count;
        logic [COUNT_W-1:0]       replacement_count;
        logic [COUNT_W-1:0]       fault_count;
    } outcome_t;

    class replacement_tracker;
        bit                 ref_bit[FRAME_COUNT];
        bit                 mod_bit[FRAME_COUNT];
        int                 hand;
        logic [COUNT_W-1:0] refs;
        logic [COUNT_W-1:0] repls;
        logic [COUNT_W-1:0] faults;
        outcome_t           awaited[$];
        int                 mismatches;

        function new();
            foreach (ref_bit[i])
            begin
                ref_bit[i] = 0;
                mod_bit[i] = 0;
            end
            hand = 0;
            refs = '0;
            repls = '0;
            faults = '0;
            mismatches = 0;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v == '1) ? v : v + COUNT_W'(1);
        endfunction

        function int sweep_clock();
            int h;
            int victim;
            victim = 0;
            for (int v = 0; v < 2 * FRAME_COUNT; v++)
            begin
                h = hand;
                hand = (h + 1) % FRAME_COUNT;
                if (!ref_bit[h])
                begin
                    victim = h;
                    break;
                end
                ref_bit[h] = 0;
            end
            ref_bit[victim] = 0;
            mod_bit[victim] = 0;
            repls = bump(repls);
            return victim;
        endfunction

        function void note_event(opcode_t op, logic [FRAME_FIELD_W-1:0] fr, logic wr);
            outcome_t want;
            int       victim;
            bit       found;
            victim = 0;
            found = 0;
            case (op)
                OP_HIT:
                begin
                    refs = bump(refs);
                    if (int'(fr) < FRAME_COUNT)
                    begin
                        ref_bit[fr] = 1;
                        if (wr)
                            mod_bit[fr] = 1;
                    end
                end
                OP_FAULT:
                begin
                    refs = bump(refs);
                    faults = bump(faults);
                    victim = sweep_clock();
                    found = 1;
                end
                OP_CLOCK:
                begin
                    victim = sweep_clock();
                    found = 1;
                end
                default:
                begin
                    for (int i = 0; i < FRAME_COUNT; i++)
                    begin
                        if (!ref_bit[i] && !mod_bit[i])
                        begin
                            victim = i;
                            found = 1;
                            break;
                        end
                        if (!ref_bit[i] && !found)
                        begin
                            victim = i;
                            found = 1;
                        end
                    end
                    if (found)
                    begin
                        ref_bit[victim] = 0;
                        mod_bit[victim] = 0;
                        repls = bump(repls);
                    end
                    else
                        victim = 0;
                end
            endcase
            want.victim_frame = victim[FRAME_FIELD_W-1:0];
            want.victim_found = found;
            want.reference_count = refs;
            want.replacement_count = repls;
            want.fault_count = faults;
            awaited.push_back(want);
        endfunction

        function void report(string what, outcome_t want, outcome_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected frame=%0d found=%0d refs=%0d repl=%0d faults=%0d",
                         $time, what, want.victim_frame, want.victim_found,
                         want.reference_count, want.replacement_count, want.fault_count,
                         ", got frame=%0d found=%0d refs=%0d repl=%0d faults=%0d",
                         got.victim_frame, got.victim_found, got.reference_count,
                         got.replacement_count, got.fault_count);
        endfunction

        function void check_outcome(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.victim_frame !== want.victim_frame
                || got.victim_found !== want.victim_found
                || got.reference_count !== want.reference_count
                || got.replacement_count !== want.replacement_count
                || got.fault_count !== want.fault_count)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                     clk = 0;
    logic                     rst_n = 0;
    logic                     in_valid = 0;
    logic                     in_stall;
    opcode_t                  opcode = OP_HIT;
    logic [FRAME_FIELD_W-1:0] frame = '0;
    logic                     is_write = 0;
    logic                     out_valid;
    logic                     out_stall = 0;
    logic [FRAME_FIELD_W-1:0] victim_frame;
    logic                     victim_found;
    logic [COUNT_W-1:0]       reference_count;
    logic [COUNT_W-1:0]       replacement_count;
    logic [COUNT_W-1:0]       fault_count;

    replacement_tracker tracker = new();
    int                 sent = 0;
    int                 cycle_count = 0;
    bit                 calm = 0;
    bit                 hold_pending = 0;
    outcome_t           seen;

    clock_nru_page_replacement #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .frame(frame),
        .is_write(is_write),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .victim_frame(victim_frame),
        .victim_found(victim_found),
        .reference_count(reference_count),
        .replacement_count(replacement_count),
        .fault_count(fault_count)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** clock_nru_page_replacement: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.victim_frame = victim_frame;
            seen.victim_found = victim_found;
            seen.reference_count = reference_count;
            seen.replacement_count = replacement_count;
            seen.fault_count = fault_count;
            tracker.check_outcome(seen);
        end
    end

    // receiver: random stall bursts, one long hold-off, none in the calm tail
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_pending)
            begin
                hold_pending = 0;
                stall_left = HOLD_CYCLES;
            end
            else if (!calm && rst_n && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 14);
            out_stall <= (stall_left > 0);
        end
    end

    task automatic send_item(input opcode_t op, input logic [FRAME_FIELD_W-1:0] fr,
                             input logic wr);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        opcode <= op;
        frame <= fr;
        is_write <= wr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_event(op, fr, wr);
        sent++;
        if (sent == HOLD_AT)
            hold_pending = 1;
    endtask

    task automatic send_any();
        send_item(opcode_t'($urandom_range(0, 3)), FRAME_FIELD_W'($urandom),
                  1'($urandom));
    endtask

    task automatic fill_frames(input bit write_all, input int skip_odds);
        int start;
        start = $urandom_range(0, FRAME_COUNT - 1);
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            if (skip_odds == 0 || $urandom_range(1, skip_odds) != 1)
                send_item(OP_HIT, FRAME_FIELD_W'((start + i) % FRAME_COUNT),
                          write_all ? 1'b1 : 1'($urandom));
        end
    endtask

    initial
    begin
        int base;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_item(OP_HIT, 6'd0, 1'b0);
        send_item(OP_HIT, 6'd63, 1'b1);
        send_item(OP_HIT, 6'd63, 1'b0);
        send_item(OP_NRU, 6'd0, 1'b0);
        send_item(OP_CLOCK, 6'd0, 1'b0);
        send_item(OP_FAULT, 6'd0, 1'b0);
        send_item(OP_HIT, 6'd42, 1'b1);
        send_item(OP_HIT, 6'd21, 1'b0);
        send_item(OP_NRU, 6'd63, 1'b1);
        send_item(OP_FAULT, 6'd63, 1'b1);
        send_item(OP_CLOCK, 6'd42, 1'b1);
        send_item(OP_HIT, 6'd1, 1'b1);
        send_item(OP_NRU, 6'd21, 1'b0);
        send_item(OP_CLOCK, 6'd0, 1'b0);

        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send_any();
                4, 5:
                begin
                    base = $urandom_range(0, FRAME_COUNT - 1);
                    n = $urandom_range(2, 10);
                    repeat (n)
                        send_item(OP_HIT, FRAME_FIELD_W'(base + $urandom_range(0, 5)),
                                  1'($urandom));
                    send_item(OP_FAULT, FRAME_FIELD_W'($urandom), 1'($urandom));
                end
                6:
                begin
                    fill_frames(0, 0);
                    send_item(OP_NRU, FRAME_FIELD_W'($urandom), 1'($urandom));
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_item(opcode_t'($urandom_range(1, 3)), FRAME_FIELD_W'($urandom),
                                  1'($urandom));
                end
                7:
                begin
                    fill_frames(1, 0);
                    send_item(OP_CLOCK, FRAME_FIELD_W'($urandom), 1'($urandom));
                    fill_frames(1, 8);
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_item(OP_NRU, FRAME_FIELD_W'($urandom), 1'($urandom));
                end
                8:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_item(OP_NRU, FRAME_FIELD_W'($urandom), 1'($urandom));
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_item(opcode_t'($urandom_range(1, 2)), FRAME_FIELD_W'($urandom),
                                  1'($urandom));
                end
            endcase
        end
        in_valid <= 0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("** clock_nru_page_replacement: PASSED **");
        else
            $display("** clock_nru_page_replacement: FAILED **");
        $finish;
    end
endmodule
